@@ sv/bbog_pkg.sv @@
`default_nettype none
package bbog_pkg;

    localparam int MAX_BATCH_DIMS_DEF = 4;
    localparam int DIM_SIZE_BITS_DEF  = 16;
    localparam int OFFSET_BITS_DEF    = 48;

    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 64;
    localparam int NUM_DIMS_BITS     = 3;
    localparam int SIZES_BITS        = 64;
    localparam int MASK_BITS         = 4;
    localparam int MATRIX_BITS       = 32;
    localparam int OFFSET_FIELD_BITS = 48;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NUM_DIMS = 2'd0,
        REG_SIZES    = 2'd1,
        REG_MASK     = 2'd2,
        REG_MATRIX   = 2'd3
    } t_cfg_reg;

endpackage
`default_nettype wire

@@ sv/bbog_cfg.sv @@
`default_nettype none
module bbog_cfg #(
    parameter int MAX_BATCH_DIMS = bbog_pkg::MAX_BATCH_DIMS_DEF,
    parameter int DIM_SIZE_BITS  = bbog_pkg::DIM_SIZE_BITS_DEF,
    parameter int OFFSET_BITS    = bbog_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_wr,
    input  wire logic [bbog_pkg::CFG_INDEX_BITS-1:0]       i_index,
    input  wire logic [bbog_pkg::CFG_DATA_BITS-1:0]        i_data,
    output logic                                           o_busy,
    output logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0]   o_size,
    output logic [MAX_BATCH_DIMS-1:0]                      o_act,
    output logic [MAX_BATCH_DIMS-1:0]                      o_use,
    output logic [MAX_BATCH_DIMS-1:0][OFFSET_BITS-1:0]     o_stride,
    output logic [MAX_BATCH_DIMS-1:0]                      o_big
);
    import bbog_pkg::*;

    localparam int SET_W = $clog2(MAX_BATCH_DIMS + 2);
    localparam logic [SET_W-1:0] SET_CYC = SET_W'(MAX_BATCH_DIMS + 1);
    localparam int PROD_W = OFFSET_BITS + DIM_SIZE_BITS;
    localparam logic [OFFSET_BITS-1:0] LIM = '1;

    logic [NUM_DIMS_BITS-1:0] r_num;
    logic [SIZES_BITS-1:0]    r_sizes;
    logic [MASK_BITS-1:0]     r_mask;
    logic [MATRIX_BITS-1:0]   r_ms;
    logic [SET_W-1:0]         r_settle;
    logic [MAX_BATCH_DIMS-1:0][OFFSET_BITS-1:0] r_stride;
    logic [MAX_BATCH_DIMS-1:0]                  r_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num    <= '0;
            r_sizes  <= '0;
            r_mask   <= '0;
            r_ms     <= MATRIX_BITS'(1);
            r_settle <= SET_CYC;
        end else begin
            if (i_wr) begin
                case (t_cfg_reg'(i_index))
                    REG_NUM_DIMS: begin
                        r_num <= i_data[NUM_DIMS_BITS-1:0];
                    end
                    REG_SIZES: begin
                        r_sizes <= i_data[SIZES_BITS-1:0];
                    end
                    REG_MASK: begin
                        r_mask <= i_data[MASK_BITS-1:0];
                    end
                    REG_MATRIX: begin
                        r_ms <= i_data[MATRIX_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
                r_settle <= SET_CYC;
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    assign o_busy = (r_settle != '0);

    for (genvar d = 0; d < MAX_BATCH_DIMS; d++) begin : g_dim
        logic bc;

        // dimension 0 sits in the top field; fields past bit 0 read as size 1
        if ((d + 1) * DIM_SIZE_BITS <= SIZES_BITS) begin : g_fld
            logic [DIM_SIZE_BITS-1:0] fld;
            assign fld       = r_sizes[SIZES_BITS-1-d*DIM_SIZE_BITS -: DIM_SIZE_BITS];
            assign o_size[d] = (fld == '0) ? DIM_SIZE_BITS'(1) : fld;
        end else begin : g_nofld
            assign o_size[d] = DIM_SIZE_BITS'(1);
        end

        if (d < MASK_BITS) begin : g_bc
            assign bc = r_mask[d];
        end else begin : g_nobc
            assign bc = 1'b0;
        end

        assign o_act[d] = (int'(r_num) > d);
        assign o_use[d] = o_act[d] & ~bc;
    end

    // stride chain, innermost first: one saturating multiply per register past the innermost
    for (genvar d = 0; d < MAX_BATCH_DIMS; d++) begin : g_stride
        if (d == MAX_BATCH_DIMS - 1) begin : g_inner
            always_ff @(posedge i_clk) begin
                r_stride[d] <= OFFSET_BITS'(r_ms);
                r_big[d]    <= 1'b0;
            end
        end else begin : g_outer
            logic [DIM_SIZE_BITS-1:0] fac;
            logic [PROD_W-1:0]        prod;
            logic                     hi;
            assign fac  = o_use[d+1] ? o_size[d+1] : DIM_SIZE_BITS'(1);
            assign prod = PROD_W'(r_stride[d+1]) * PROD_W'(fac);
            assign hi   = (prod[PROD_W-1:OFFSET_BITS] != '0);
            always_ff @(posedge i_clk) begin
                r_stride[d] <= hi ? LIM : prod[OFFSET_BITS-1:0];
                r_big[d]    <= r_big[d+1] | hi;
            end
        end
    end

    assign o_stride = r_stride;
    assign o_big    = r_big;

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |=> o_busy)
        else $error("config write did not restart stride settling");

endmodule
`default_nettype wire

@@ sv/bbog_walk.sv @@
`default_nettype none
module bbog_walk #(
    parameter int MAX_BATCH_DIMS = bbog_pkg::MAX_BATCH_DIMS_DEF,
    parameter int DIM_SIZE_BITS  = bbog_pkg::DIM_SIZE_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_load,
    input  wire logic                                      i_restart,
    input  wire logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] i_size,
    input  wire logic [MAX_BATCH_DIMS-1:0]                 i_act,
    output logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0]   o_cnt
);
    import bbog_pkg::*;

    logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] r_cnt;
    logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] n_cnt;
    logic [MAX_BATCH_DIMS-1:0]                    wrap;
    logic [MAX_BATCH_DIMS-1:0]                    cin;

    for (genvar d = 0; d < MAX_BATCH_DIMS; d++) begin : g_wrap
        assign wrap[d] = ({1'b0, r_cnt[d]} + 1'b1) >= {1'b0, i_size[d]};
    end

    // carry into a dimension: every active inner dimension wraps
    always_comb begin
        cin[MAX_BATCH_DIMS-1] = 1'b1;
        for (int d = MAX_BATCH_DIMS - 2; d >= 0; d--) begin
            cin[d] = cin[d+1] & (~i_act[d+1] | wrap[d+1]);
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_BATCH_DIMS; d++) begin
            if (i_restart) begin
                n_cnt[d] = '0;
            end else if (i_act[d] && cin[d]) begin
                n_cnt[d] = wrap[d] ? '0 : r_cnt[d] + 1'b1;
            end else begin
                n_cnt[d] = r_cnt[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = n_cnt;

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_restart) |=> (r_cnt == '0))
        else $error("restart left a nonzero batch index");

endmodule
`default_nettype wire

@@ sv/bbog_calc.sv @@
`default_nettype none
module bbog_calc #(
    parameter int MAX_BATCH_DIMS = bbog_pkg::MAX_BATCH_DIMS_DEF,
    parameter int DIM_SIZE_BITS  = bbog_pkg::DIM_SIZE_BITS_DEF,
    parameter int OFFSET_BITS    = bbog_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_load,
    input  wire logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] i_cnt,
    input  wire logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] i_size,
    input  wire logic [MAX_BATCH_DIMS-1:0]                 i_act,
    input  wire logic [MAX_BATCH_DIMS-1:0]                 i_use,
    input  wire logic [MAX_BATCH_DIMS-1:0][OFFSET_BITS-1:0] i_stride,
    input  wire logic [MAX_BATCH_DIMS-1:0]                 i_big,
    input  wire logic                                      i_stall,
    output logic                                           o_ready,
    output logic                                           o_valid,
    output logic [bbog_pkg::OFFSET_FIELD_BITS-1:0]         o_offset,
    output logic                                           o_last,
    output logic                                           o_overflow
);
    import bbog_pkg::*;

    localparam int PROD_W = OFFSET_BITS + DIM_SIZE_BITS;
    localparam int SUM_W  = OFFSET_BITS + $clog2(MAX_BATCH_DIMS + 1);
    localparam logic [OFFSET_BITS-1:0] LIM = '1;

    logic en1, en2, en3;

    logic                                         r1_v;
    logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] r1_cnt;

    logic                                         r2_v;
    logic [MAX_BATCH_DIMS-1:0][OFFSET_BITS-1:0]   r2_con;
    logic                                         r2_flag;
    logic                                         r2_last;
    logic [MAX_BATCH_DIMS-1:0][OFFSET_BITS-1:0]   n2_con;
    logic [MAX_BATCH_DIMS-1:0]                    n2_fl;
    logic [MAX_BATCH_DIMS-1:0]                    n2_done;

    logic                                         r3_v;
    logic [OFFSET_BITS-1:0]                       r3_off;
    logic                                         r3_last;
    logic                                         r3_ovf;
    logic [SUM_W-1:0]                             n3_sum;
    logic                                         n3_ovf;

    // bubbles collapse: a stage moves when the one after it is empty or moving
    assign en3     = ~r3_v | ~i_stall;
    assign en2     = ~r2_v | en3;
    assign en1     = ~r1_v | en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_load;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
        end
    end

    // per-dimension term: index times stride, saturated
    for (genvar d = 0; d < MAX_BATCH_DIMS; d++) begin : g_term
        logic [PROD_W-1:0] prod;
        assign prod = PROD_W'(i_stride[d]) * PROD_W'(r1_cnt[d]);
        assign n2_done[d] = ~i_act[d] |
                            (({1'b0, r1_cnt[d]} + 1'b1) >= {1'b0, i_size[d]});

        always_comb begin
            if (!i_use[d] || r1_cnt[d] == '0) begin
                n2_con[d] = '0;
                n2_fl[d]  = 1'b0;
            end else if (i_big[d] || prod[PROD_W-1:OFFSET_BITS] != '0) begin
                n2_con[d] = LIM;
                n2_fl[d]  = 1'b1;
            end else begin
                n2_con[d] = prod[OFFSET_BITS-1:0];
                n2_fl[d]  = 1'b0;
            end
        end
    end

    always_comb begin
        n3_sum = '0;
        for (int d = 0; d < MAX_BATCH_DIMS; d++) begin
            n3_sum = n3_sum + SUM_W'(r2_con[d]);
        end
        n3_ovf = r2_flag | (n3_sum > SUM_W'(LIM));
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_load) begin
            r1_cnt <= i_cnt;
        end
        if (en2) begin
            r2_con  <= n2_con;
            r2_flag <= |n2_fl;
            r2_last <= &n2_done;
        end
        if (en3) begin
            r3_off  <= n3_ovf ? LIM : n3_sum[OFFSET_BITS-1:0];
            r3_last <= r2_last;
            r3_ovf  <= n3_ovf;
        end
    end

    if (OFFSET_BITS >= OFFSET_FIELD_BITS) begin : g_trunc
        assign o_offset = r3_off[OFFSET_FIELD_BITS-1:0];
    end else begin : g_ext
        assign o_offset = OFFSET_FIELD_BITS'(r3_off);
    end

    assign o_valid    = r3_v;
    assign o_last     = r3_last;
    assign o_overflow = r3_ovf;

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (r3_off == LIM))
        else $error("overflow raised without saturated offset");

    a_flag_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && r2_flag && en3) |=> o_overflow)
        else $error("saturated term did not raise overflow");

endmodule
`default_nettype wire

@@ sv/broadcast_batch_offset_generator_top.sv @@
`default_nettype none
// Batch offset generator: one operand-matrix element offset per input beat,
// walking output batch entries row-major with broadcast dimensions rewound.
// Throughput is one beat per cycle while i_stall and stride settling allow; a
// beat passes the input register holding the updated counters, the per-dimension
// multiply and the saturating sum into the output register before its result is
// presented. Strides are kept in a chain of registers, one 48x16 multiply per
// dimension but the innermost, so after reset and after every configuration write
// the input stalls while that chain settles.
// Configuration is always ready; write it only while no beats are in flight.
module broadcast_batch_offset_generator_top #(
    parameter int MAX_BATCH_DIMS = bbog_pkg::MAX_BATCH_DIMS_DEF,
    parameter int DIM_SIZE_BITS  = bbog_pkg::DIM_SIZE_BITS_DEF,
    parameter int OFFSET_BITS    = bbog_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bbog_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [bbog_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_restart,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [bbog_pkg::OFFSET_FIELD_BITS-1:0]    o_offset,
    output logic                                      o_last,
    output logic                                      o_overflow
);
    import bbog_pkg::*;

    logic                                         busy;
    logic                                         ready;
    logic                                         accept;
    logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] size;
    logic [MAX_BATCH_DIMS-1:0]                    act;
    logic [MAX_BATCH_DIMS-1:0]                    use_dim;
    logic [MAX_BATCH_DIMS-1:0][OFFSET_BITS-1:0]   stride;
    logic [MAX_BATCH_DIMS-1:0]                    big;
    logic [MAX_BATCH_DIMS-1:0][DIM_SIZE_BITS-1:0] cnt;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid & ready & ~busy;
    assign o_stall     = ~ready | busy;

    bbog_cfg #(
        .MAX_BATCH_DIMS (MAX_BATCH_DIMS),
        .DIM_SIZE_BITS  (DIM_SIZE_BITS),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid & o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_busy   (busy),
        .o_size   (size),
        .o_act    (act),
        .o_use    (use_dim),
        .o_stride (stride),
        .o_big    (big)
    );

    bbog_walk #(
        .MAX_BATCH_DIMS (MAX_BATCH_DIMS),
        .DIM_SIZE_BITS  (DIM_SIZE_BITS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_restart (i_restart),
        .i_size    (size),
        .i_act     (act),
        .o_cnt     (cnt)
    );

    bbog_calc #(
        .MAX_BATCH_DIMS (MAX_BATCH_DIMS),
        .DIM_SIZE_BITS  (DIM_SIZE_BITS),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_cnt      (cnt),
        .i_size     (size),
        .i_act      (act),
        .i_use      (use_dim),
        .i_stride   (stride),
        .i_big      (big),
        .i_stall    (i_stall),
        .o_ready    (ready),
        .o_valid    (o_valid),
        .o_offset   (o_offset),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_stall)
        else $error("input beat taken while strides settle");

endmodule
`default_nettype wire

@@ tb/tb_broadcast_batch_offset_generator_top.sv @@
module tb_broadcast_batch_offset_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bbog_pkg::*;

    localparam int MAX_DIMS = MAX_BATCH_DIMS_DEF;
    localparam longint unsigned OFS_LIM = 64'h0000_FFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [OFFSET_FIELD_BITS-1:0] offset;
        logic                         last;
        logic                         overflow;
    } t_batch_result;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data  = '0;
    logic                         i_valid     = 1'b0;
    logic                         o_stall;
    logic                         i_restart   = 1'b0;
    logic                         o_valid;
    logic                         i_stall     = 1'b0;
    logic [OFFSET_FIELD_BITS-1:0] o_offset;
    logic                         o_last;
    logic                         o_overflow;

    broadcast_batch_offset_generator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_restart  (i_restart),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_offset   (o_offset),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the block's registers and batch walk
    logic [NUM_DIMS_BITS-1:0] cfg_num_dims = '0;
    logic [SIZES_BITS-1:0]    cfg_sizes    = '0;
    logic [MASK_BITS-1:0]     cfg_mask     = '0;
    logic [MATRIX_BITS-1:0]   cfg_matrix   = 32'd1;
    int unsigned              batch_idx [MAX_DIMS] = '{default: 0};

    t_batch_result pending_offsets [$];
    int mismatches    = 0;
    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    function automatic longint unsigned dim_extent(input int d);
        logic [15:0] f;
        f = cfg_sizes[63-16*d -: 16];
        return (f == 0) ? 64'd1 : {48'd0, f};
    endfunction

    function automatic longint unsigned sat_mul(input longint unsigned a,
                                                input longint unsigned b,
                                                inout bit big);
        if (a == 0 || b == 0)
            return 0;
        if (a > OFS_LIM / b) begin
            big = 1'b1;
            return OFS_LIM;
        end
        return a * b;
    endfunction

    function automatic longint unsigned sat_add(input longint unsigned a,
                                                input longint unsigned b,
                                                inout bit big);
        if (b > OFS_LIM - a) begin
            big = 1'b1;
            return OFS_LIM;
        end
        return a + b;
    endfunction

    // Steps the batch walk for one beat and returns the offset it selects.
    function automatic t_batch_result next_batch_offset(input logic restart);
        t_batch_result   res;
        int              n;
        int              d;
        bit              carry;
        bit              stride_big;
        bit              ovf;
        bit              last;
        longint unsigned stride;
        longint unsigned sum;
        longint unsigned contrib [MAX_DIMS];

        n = (cfg_num_dims > MAX_DIMS) ? MAX_DIMS : int'(cfg_num_dims);
        if (restart) begin
            for (d = 0; d < MAX_DIMS; d++)
                batch_idx[d] = 0;
        end else begin
            carry = 1'b1;
            for (d = n - 1; d >= 0; d--) begin
                if (carry) begin
                    if (batch_idx[d] + 1 >= dim_extent(d)) begin
                        batch_idx[d] = 0;
                    end else begin
                        batch_idx[d]++;
                        carry = 1'b0;
                    end
                end
            end
        end

        stride     = 64'(cfg_matrix);
        stride_big = 1'b0;
        ovf        = 1'b0;
        last       = 1'b1;
        for (d = 0; d < MAX_DIMS; d++)
            contrib[d] = 0;
        for (d = n - 1; d >= 0; d--) begin
            if (batch_idx[d] + 1 < dim_extent(d))
                last = 1'b0;
            // broadcast dims add nothing and do not grow the stride
            if (!cfg_mask[d]) begin
                if (batch_idx[d] != 0) begin
                    if (stride_big) begin
                        ovf        = 1'b1;
                        contrib[d] = OFS_LIM;
                    end else begin
                        contrib[d] = sat_mul(64'(batch_idx[d]), stride, ovf);
                    end
                end
                stride = sat_mul(stride, dim_extent(d), stride_big);
            end
        end

        sum = 0;
        for (d = 0; d < n; d++)
            sum = sat_add(sum, contrib[d], ovf);
        if (ovf)
            sum = OFS_LIM;

        res.offset   = sum[OFFSET_FIELD_BITS-1:0];
        res.last     = last;
        res.overflow = ovf;
        return res;
    endfunction

    // Entered and left at a falling edge; valid stays up for a following beat.
    task automatic send_beat(input logic restart);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_offsets.push_back(next_batch_offset(restart));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_offsets.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            REG_NUM_DIMS: cfg_num_dims = data[NUM_DIMS_BITS-1:0];
            REG_SIZES:    cfg_sizes    = data[SIZES_BITS-1:0];
            REG_MASK:     cfg_mask     = data[MASK_BITS-1:0];
            REG_MATRIX:   cfg_matrix   = data[MATRIX_BITS-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    // Drains the beats in flight before writing the registers.
    task automatic set_geometry(input logic [63:0] dims_word, input logic [63:0] sizes,
                                input logic [63:0] mask_word, input logic [63:0] matrix_word);
        wait_idle();
        write_reg(REG_NUM_DIMS, dims_word);
        write_reg(REG_SIZES, sizes);
        write_reg(REG_MASK, mask_word);
        write_reg(REG_MATRIX, matrix_word);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_no_batch_dims();
        send_beat(1'b0);
        send_beat(1'b1);
        wait_idle();
    endtask

    // counters still sit at entry 0, so a plain advance lands on entry 1
    task automatic test_advance_after_reset();
        set_geometry(64'd2, {16'd3, 16'd2, 32'd0}, 64'd0, 64'd5);
        send_beat(1'b0);
        wait_idle();
    endtask

    task automatic test_wrap_and_broadcast();
        repeat (6)
            send_beat(1'b0);
        set_geometry(64'd2, {16'd3, 16'd2, 32'd0}, 64'd1, 64'd5);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        wait_idle();
    endtask

    // seven dims clamp to four; zero-sized fields count as one
    task automatic test_clamped_dims_and_zero_sizes();
        set_geometry(64'd7, 64'h0000_0002_0000_0003, 64'h8, 64'hFFFF_FFFF);
        send_beat(1'b1);
        repeat (3)
            send_beat(1'b0);
        wait_idle();
    endtask

    task automatic test_zero_matrix();
        set_geometry(64'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
        send_beat(1'b1);
        send_beat(1'b0);
        wait_idle();
    endtask

    // leave dim 0 at index 1, then grow the inner dims until the stride saturates,
    // then shrink everything so the counters sit past their sizes
    task automatic test_stale_counters_and_overflow();
        set_geometry(64'd3, {16'd2, 16'd1, 16'd1, 16'd0}, 64'd0, 64'hFFFF_FFFF);
        send_beat(1'b1);
        send_beat(1'b0);
        set_geometry(64'd3, {16'd2, 16'hFFFF, 16'hFFFF, 16'd0}, 64'd0, 64'hFFFF_FFFF);
        send_beat(1'b0);
        set_geometry(64'd3, {16'd1, 16'd1, 16'd1, 16'd0}, 64'd0, 64'hFFFF_FFFF);
        send_beat(1'b0);
        wait_idle();
    endtask

    task automatic set_random_geometry();
        logic [63:0] dims_word;
        logic [63:0] sizes;
        logic [63:0] matrix_word;
        int          d;

        dims_word = {$urandom(), $urandom()};
        dims_word[NUM_DIMS_BITS-1:0] = ($urandom_range(9) == 0)
                                       ? NUM_DIMS_BITS'($urandom_range(5, 7))
                                       : NUM_DIMS_BITS'($urandom_range(0, 4));
        if ($urandom_range(9) == 0) begin
            sizes = {$urandom(), $urandom()};
        end else begin
            for (d = 0; d < MAX_DIMS; d++) begin
                case ($urandom_range(9))
                    0:       sizes[63-16*d -: 16] = 16'd0;
                    1:       sizes[63-16*d -: 16] = 16'hFFFF;
                    2:       sizes[63-16*d -: 16] = 16'($urandom_range(16'hFFFF));
                    default: sizes[63-16*d -: 16] = 16'($urandom_range(1, 3));
                endcase
            end
        end
        matrix_word = {$urandom(), $urandom()};
        case ($urandom_range(7))
            0:       matrix_word[31:0] = 32'd0;
            1:       matrix_word[31:0] = 32'hFFFF_FFFF;
            2:       matrix_word[31:0] = 32'd1;
            3:       matrix_word[31:0] = $urandom();
            default: matrix_word[31:0] = $urandom_range(1, 4096);
        endcase
        set_geometry(dims_word, sizes, {$urandom(), $urandom()}, matrix_word);
    endtask

    // Mostly straight walks with random content; some start mid-walk from the
    // previous geometry's counters, and stray restarts break the walk.
    task automatic run_random_items(input int count);
        int sent;
        int seg_len;
        int k;

        sent = 0;
        while (sent < count) begin
            set_random_geometry();
            seg_len = $urandom_range(8, 50);
            for (k = 0; k < seg_len; k++) begin
                if (k == 0)
                    send_beat($urandom_range(9) < 7);
                else
                    send_beat($urandom_range(99) < 6);
            end
            sent += seg_len;
        end
        wait_idle();
    endtask

    // output held off for a long stretch while beats keep coming
    task automatic test_output_hold_off();
        int k;

        set_geometry(64'd4, {16'd2, 16'd3, 16'd2, 16'd2}, 64'h4, 64'd7);
        hold_req = 1'b1;
        send_beat(1'b1);
        for (k = 0; k < 23; k++)
            send_beat(1'b0);
        wait_idle();
        send_beat(1'b0);
        send_beat(1'b1);
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        t_batch_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_offsets.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat offset=%h last=%b overflow=%b",
                         $time, o_offset, o_last, o_overflow);
            end else begin
                want = pending_offsets.pop_front();
                if (o_offset !== want.offset) begin
                    mismatches++;
                    $display("%0t: offset expected %h actual %h", $time, want.offset, o_offset);
                end
                if (o_last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                end
                if (o_overflow !== want.overflow) begin
                    mismatches++;
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.overflow, o_overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d beats outstanding",
                     $time, STALL_LIMIT, pending_offsets.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (3)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 35;
        recv_gap_pct = 53;
        test_no_batch_dims();
        test_advance_after_reset();
        test_wrap_and_broadcast();
        test_clamped_dims_and_zero_sizes();
        test_zero_matrix();
        test_stale_counters_and_overflow();
        run_random_items(350);

        send_gap_pct = 53;
        recv_gap_pct = 35;
        run_random_items(350);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_output_hold_off();
        run_random_items(350);

        wait_idle();
        repeat (8)
            @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
